// File: hdl/qs_pkg.sv
// ----------------------------------------------------------------------------
// qs_pkg
// shared widths, constants and helpers for the quaternion slerp pipeline
// ----------------------------------------------------------------------------
package qs_pkg;

    localparam int FW           = 18;
    localparam int CW           = 34;
    localparam int CORDIC_STEPS = 30;

    localparam logic signed [CW-1:0] CORDIC_START = 34'sd652032874;
    localparam logic [36:0]          NEAR_LIMIT   = 37'd4273492480;
    localparam logic [16:0]          ONE_Q16      = 17'd65536;
    localparam logic signed [FW-1:0] SAT_HI       = 18'sd131071;
    localparam logic signed [FW-1:0] SAT_LO       = -18'sd131072;

    function automatic logic signed [CW-1:0] atan_q30(input int i);
        logic signed [CW-1:0] r;
        case (i)
            0:  r = 34'sd843314857;
            1:  r = 34'sd497837829;
            2:  r = 34'sd263043837;
            3:  r = 34'sd133525159;
            4:  r = 34'sd67021687;
            5:  r = 34'sd33543516;
            6:  r = 34'sd16775851;
            7:  r = 34'sd8388437;
            8:  r = 34'sd4194283;
            9:  r = 34'sd2097149;
            10: r = 34'sd1048576;
            11: r = 34'sd524288;
            12: r = 34'sd262144;
            13: r = 34'sd131072;
            14: r = 34'sd65536;
            15: r = 34'sd32768;
            16: r = 34'sd16384;
            17: r = 34'sd8192;
            18: r = 34'sd4096;
            19: r = 34'sd2048;
            20: r = 34'sd1024;
            21: r = 34'sd512;
            22: r = 34'sd256;
            23: r = 34'sd128;
            24: r = 34'sd64;
            25: r = 34'sd32;
            26: r = 34'sd16;
            27: r = 34'sd8;
            28: r = 34'sd4;
            29: r = 34'sd2;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [FW-1:0] sat_field(input logic signed [FW:0] v);
        logic signed [FW-1:0] r;
        if (v > 19'(SAT_HI)) begin
            r = SAT_HI;
        end else if (v < 19'(SAT_LO)) begin
            r = SAT_LO;
        end else begin
            r = v[FW-1:0];
        end
        return r;
    endfunction

endpackage

// File: hdl/qs_isqrt.sv
// ----------------------------------------------------------------------------
// qs_isqrt
// pipelined integer square root, one result bit per stage, sideband carried
// ----------------------------------------------------------------------------
module qs_isqrt #(
    parameter int NW = 62,
    parameter int SW = 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [NW-1:0]         num_in,
    input  logic [SW-1:0]         side_in,
    output logic                  out_valid,
    output logic [(NW+1)/2-1:0]   root_out,
    output logic [SW-1:0]         side_out
);
    localparam int N  = (NW + 1) / 2;
    localparam int RW = NW + 1;

    logic [NW-1:0] n_reg    [N];
    logic [RW-1:0] r_reg    [N];
    logic [SW-1:0] side_reg [N];
    logic [N-1:0]  v_reg;

    for (genvar i = 0; i < N; i++) begin : g_step
        localparam logic [RW-1:0] BITV = RW'(1) << (2 * (N - 1 - i));
        logic [NW-1:0] np, n_next;
        logic [RW-1:0] rp, r_next, trial;
        logic [SW-1:0] sp;
        logic          vp;

        if (i == 0) begin : g_first
            assign np = num_in;
            assign rp = '0;
            assign sp = side_in;
            assign vp = in_valid;
        end else begin : g_rest
            assign np = n_reg[i-1];
            assign rp = r_reg[i-1];
            assign sp = side_reg[i-1];
            assign vp = v_reg[i-1];
        end

        always_comb begin
            trial = rp + BITV;
            if ({1'b0, np} >= trial) begin
                n_next = np - trial[NW-1:0];
                r_next = (rp >> 1) + BITV;
            end else begin
                n_next = np;
                r_next = rp >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (en) begin
                v_reg[i] <= vp;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[i]    <= n_next;
                r_reg[i]    <= r_next;
                side_reg[i] <= sp;
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign root_out  = r_reg[N-1][N-1:0];
    assign side_out  = side_reg[N-1];

endmodule

// File: hdl/qs_cordic.sv
// ----------------------------------------------------------------------------
// qs_cordic
// pipelined cordic, one micro-rotation per stage, vectoring or rotation mode
// ----------------------------------------------------------------------------
module qs_cordic #(
    parameter int LANES     = 1,
    parameter int SW        = 1,
    parameter bit VECTORING = 1'b0
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic signed [qs_pkg::CW-1:0]   x_in    [LANES],
    input  logic signed [qs_pkg::CW-1:0]   y_in    [LANES],
    input  logic signed [qs_pkg::CW-1:0]   z_in    [LANES],
    input  logic [SW-1:0]                  side_in,
    output logic                           out_valid,
    output logic signed [qs_pkg::CW-1:0]   res_out [LANES],
    output logic [SW-1:0]                  side_out
);
    import qs_pkg::*;

    localparam int N = CORDIC_STEPS;

    logic signed [CW-1:0] x_reg [N][LANES];
    logic signed [CW-1:0] y_reg [N][LANES];
    logic signed [CW-1:0] z_reg [N][LANES];
    logic [SW-1:0]        side_reg [N];
    logic [N-1:0]         v_reg;

    for (genvar i = 0; i < N; i++) begin : g_step
        logic signed [CW-1:0] xp [LANES];
        logic signed [CW-1:0] yp [LANES];
        logic signed [CW-1:0] zp [LANES];
        logic signed [CW-1:0] x_next [LANES];
        logic signed [CW-1:0] y_next [LANES];
        logic signed [CW-1:0] z_next [LANES];
        logic [SW-1:0]        sp;
        logic                 vp;

        if (i == 0) begin : g_first
            assign xp = x_in;
            assign yp = y_in;
            assign zp = z_in;
            assign sp = side_in;
            assign vp = in_valid;
        end else begin : g_rest
            assign xp = x_reg[i-1];
            assign yp = y_reg[i-1];
            assign zp = z_reg[i-1];
            assign sp = side_reg[i-1];
            assign vp = v_reg[i-1];
        end

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                logic signed [CW-1:0] u, w;
                logic                 pos;
                u   = yp[l] >>> i;
                w   = xp[l] >>> i;
                pos = VECTORING ? !yp[l][CW-1] : zp[l][CW-1];
                if (pos) begin
                    x_next[l] = xp[l] + u;
                    y_next[l] = yp[l] - w;
                    z_next[l] = zp[l] + atan_q30(i);
                end else begin
                    x_next[l] = xp[l] - u;
                    y_next[l] = yp[l] + w;
                    z_next[l] = zp[l] - atan_q30(i);
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (en) begin
                v_reg[i] <= vp;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[i]    <= x_next;
                y_reg[i]    <= y_next;
                z_reg[i]    <= z_next;
                side_reg[i] <= sp;
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            res_out[l] = VECTORING ? z_reg[N-1][l] : y_reg[N-1][l];
        end
    end

    assign out_valid = v_reg[N-1];
    assign side_out  = side_reg[N-1];

endmodule

// File: hdl/quat_slerp.sv
// ----------------------------------------------------------------------------
// quat_slerp
// spherical linear interpolation of two q2.16 quaternions, fully pipelined
// ----------------------------------------------------------------------------
// throughput: one word per cycle while no result waits; the longest chains are the two 31-stage
//   square roots and the two 30-stage cordic pipes
// the whole pipeline advances together; it holds while a result waits
// reset: synchronous active-low aresetn clears all valid bits, no data reset
// ----------------------------------------------------------------------------
module quat_slerp (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [167:0] s_tdata,  // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, blend, zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata   // r_x, r_y, r_z, r_w
);
    import qs_pkg::*;

    localparam int MW = 54;

    typedef logic signed [FW-1:0] fld_t;
    typedef logic signed [FW:0]   fldw_t;

    typedef struct packed {
        logic             direct;
        logic [3:0][FW-1:0] r_dir;
    } tail_t;

    typedef struct packed {
        tail_t              tl;
        logic               near;
        logic [3:0][FW-1:0] a;
        logic [3:0][FW:0]   bn;
        logic [16:0]        t;
    } carry_t;

    typedef struct packed {
        carry_t      c;
        logic [29:0] dq;
    } sq_side_t;

    typedef struct packed {
        tail_t            tl;
        logic [3:0]       sgn;
        logic             zero;
        logic [3:0][29:0] mag;
    } len_side_t;

    typedef struct packed {
        tail_t      tl;
        logic [3:0] sgn;
        logic       zero;
    } div_side_t;

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // input register
    logic in_v_reg;
    fld_t a1_reg [4];
    fld_t b1_reg [4];
    fld_t t1_reg;

    // products of the dot
    logic                 p_v_reg;
    logic signed [35:0]   p_reg [4];
    fld_t a2_reg [4];
    fld_t b2_reg [4];
    fld_t t2_reg;

    // dot sum
    logic                 d_v_reg;
    logic signed [37:0]   d_reg;
    fld_t a3_reg [4];
    fld_t b3_reg [4];
    fld_t t3_reg;

    // classify
    logic        c_v_reg;
    carry_t      c4_reg, c4_next;
    logic [29:0] dq4_reg, dq4_next;

    // acos argument
    logic        sq_v_reg;
    logic [59:0] sq_reg;
    carry_t      c5_reg;
    logic [29:0] dq5_reg;

    logic        rad_v_reg;
    logic [60:0] rad_reg;
    carry_t      c6_reg;
    logic [29:0] dq6_reg;

    logic                 rt1_v;
    logic [30:0]          rt1_root;
    logic [$bits(sq_side_t)-1:0] rt1_side;
    sq_side_t             rt1_s;

    logic signed [CW-1:0] ac_x [1];
    logic signed [CW-1:0] ac_y [1];
    logic signed [CW-1:0] ac_z [1];
    logic signed [CW-1:0] ac_res [1];
    logic                 ac_v;
    logic [$bits(carry_t)-1:0] ac_side;
    carry_t               ac_c;

    logic                 th_v_reg;
    logic signed [51:0]   th_reg [2];
    carry_t               cth_reg;

    logic signed [CW-1:0] sn_x [2];
    logic signed [CW-1:0] sn_y [2];
    logic signed [CW-1:0] sn_z [2];
    logic signed [CW-1:0] sn_res [2];
    logic                 sn_v;
    logic [$bits(carry_t)-1:0] sn_side;
    carry_t               sn_c;

    // weighted sum
    logic                 vp_v_reg;
    logic signed [52:0]   pa_reg [4];
    logic signed [52:0]   pb_reg [4];
    tail_t                tvp_reg;

    logic                 vs_v_reg;
    logic signed [MW-1:0] v_reg [4];
    tail_t                tvs_reg;

    logic                 mg_v_reg;
    logic [MW-1:0]        mg_reg [4];
    logic [MW-1:0]        mgb_reg;
    logic [3:0]           sgn_mg_reg;
    tail_t                tmg_reg;

    // normalize shift
    logic [MW-1:0] nm_reg  [5][4];
    logic [MW-1:0] nb_reg  [5];
    logic [3:0]    nsg_reg [5];
    tail_t         ntl_reg [5];
    logic [4:0]    nv_reg;

    logic          q2_v_reg;
    logic [59:0]   q2_reg [4];
    len_side_t     q2s_reg;

    logic          ss_v_reg;
    logic [61:0]   ss_reg;
    len_side_t     sss_reg;

    logic          rt2_v;
    logic [30:0]   rt2_root;
    logic [$bits(len_side_t)-1:0] rt2_side;
    len_side_t     rt2_s;

    logic          nn_v_reg;
    logic [46:0]   nn_reg [4];
    logic [30:0]   len_reg;
    div_side_t     nns_reg;

    // divider
    logic [30:0]   dr_reg [17][4];
    logic [16:0]   dq_reg [17][4];
    logic [16:0]   dn_reg [17][4];
    logic [30:0]   dl_reg [17];
    div_side_t     ds_reg [17];
    logic [16:0]   dv_reg;

    logic          o_v_reg;
    logic [71:0]   o_reg, o_next;

    // valid chain of the top level stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg  <= 1'b0;
            p_v_reg   <= 1'b0;
            d_v_reg   <= 1'b0;
            c_v_reg   <= 1'b0;
            sq_v_reg  <= 1'b0;
            rad_v_reg <= 1'b0;
            th_v_reg  <= 1'b0;
            vp_v_reg  <= 1'b0;
            vs_v_reg  <= 1'b0;
            mg_v_reg  <= 1'b0;
            q2_v_reg  <= 1'b0;
            ss_v_reg  <= 1'b0;
            nn_v_reg  <= 1'b0;
            o_v_reg   <= 1'b0;
        end else if (en) begin
            in_v_reg  <= s_tvalid;
            p_v_reg   <= in_v_reg;
            d_v_reg   <= p_v_reg;
            c_v_reg   <= d_v_reg;
            sq_v_reg  <= c_v_reg;
            rad_v_reg <= sq_v_reg;
            th_v_reg  <= ac_v;
            vp_v_reg  <= sn_v;
            vs_v_reg  <= vp_v_reg;
            mg_v_reg  <= vs_v_reg;
            q2_v_reg  <= nv_reg[4];
            ss_v_reg  <= q2_v_reg;
            nn_v_reg  <= rt2_v;
            o_v_reg   <= dv_reg[16];
        end
    end

    // classify stage logic
    always_comb begin
        logic               neg;
        logic [36:0]        dabs;
        logic               le0, ge1;
        fldw_t              bw;
        neg  = d_reg[37];
        dabs = neg ? 37'(-d_reg) : d_reg[36:0];
        le0  = t3_reg[FW-1] || (t3_reg == '0);
        ge1  = (t3_reg >= 18'sd65536);
        c4_next.tl.direct = le0 || ge1;
        c4_next.near      = dabs > NEAR_LIMIT;
        c4_next.t         = t3_reg[16:0];
        for (int i = 0; i < 4; i++) begin
            bw = 19'(b3_reg[i]);
            c4_next.a[i]        = a3_reg[i];
            c4_next.bn[i]       = neg ? -bw : bw;
            c4_next.tl.r_dir[i] = le0 ? a3_reg[i] : sat_field(neg ? -bw : bw);
        end
        dq4_next = dabs[31:2];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                a1_reg[i] <= s_tdata[i*FW +: FW];
                b1_reg[i] <= s_tdata[(4+i)*FW +: FW];
                p_reg[i]  <= a1_reg[i] * b1_reg[i];
                a2_reg[i] <= a1_reg[i];
                b2_reg[i] <= b1_reg[i];
                a3_reg[i] <= a2_reg[i];
                b3_reg[i] <= b2_reg[i];
            end
            t1_reg  <= s_tdata[8*FW +: FW];
            t2_reg  <= t1_reg;
            t3_reg  <= t2_reg;
            d_reg   <= 38'(p_reg[0]) + 38'(p_reg[1]) + 38'(p_reg[2]) + 38'(p_reg[3]);
            c4_reg  <= c4_next;
            dq4_reg <= dq4_next;
            sq_reg  <= dq4_reg * dq4_reg;
            c5_reg  <= c4_reg;
            dq5_reg <= dq4_reg;
            rad_reg <= (61'(1) << 60) - 61'(sq_reg);
            c6_reg  <= c5_reg;
            dq6_reg <= dq5_reg;
        end
    end

    qs_isqrt #(
        .NW (61),
        .SW ($bits(sq_side_t))
    ) u_root_acos (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (rad_v_reg),
        .num_in    (rad_reg),
        .side_in   ({c6_reg, dq6_reg}),
        .out_valid (rt1_v),
        .root_out  (rt1_root),
        .side_out  (rt1_side)
    );

    assign rt1_s   = sq_side_t'(rt1_side);
    assign ac_x[0] = CW'(rt1_s.dq);
    assign ac_y[0] = CW'(rt1_root);
    assign ac_z[0] = '0;

    qs_cordic #(
        .LANES     (1),
        .SW        ($bits(carry_t)),
        .VECTORING (1'b1)
    ) u_acos (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (rt1_v),
        .x_in      (ac_x),
        .y_in      (ac_y),
        .z_in      (ac_z),
        .side_in   (rt1_s.c),
        .out_valid (ac_v),
        .res_out   (ac_res),
        .side_out  (ac_side)
    );

    assign ac_c = carry_t'(ac_side);

    always_ff @(posedge aclk) begin
        if (en) begin
            th_reg[0] <= ac_res[0] * $signed({1'b0, ONE_Q16 - ac_c.t});
            th_reg[1] <= ac_res[0] * $signed({1'b0, ac_c.t});
            cth_reg   <= ac_c;
        end
    end

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            sn_x[k] = CORDIC_START;
            sn_y[k] = '0;
            sn_z[k] = CW'(th_reg[k] >>> 16);
        end
    end

    qs_cordic #(
        .LANES     (2),
        .SW        ($bits(carry_t)),
        .VECTORING (1'b0)
    ) u_sin (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (th_v_reg),
        .x_in      (sn_x),
        .y_in      (sn_y),
        .z_in      (sn_z),
        .side_in   (cth_reg),
        .out_valid (sn_v),
        .res_out   (sn_res),
        .side_out  (sn_side)
    );

    assign sn_c = carry_t'(sn_side);

    // weights: sines for slerp, 1-t and t for the linear blend
    always_ff @(posedge aclk) begin
        logic signed [CW-1:0] wt1, wt2;
        if (en) begin
            wt1 = sn_c.near ? CW'({1'b0, ONE_Q16 - sn_c.t}) : sn_res[0];
            wt2 = sn_c.near ? CW'({1'b0, sn_c.t}) : sn_res[1];
            for (int i = 0; i < 4; i++) begin
                pa_reg[i] <= $signed(sn_c.a[i]) * wt1;
                pb_reg[i] <= $signed(sn_c.bn[i]) * wt2;
            end
            tvp_reg <= sn_c.tl;
            for (int i = 0; i < 4; i++) begin
                v_reg[i] <= MW'(pa_reg[i]) + MW'(pb_reg[i]);
            end
            tvs_reg <= tvp_reg;
        end
    end

    // magnitudes and the largest one
    always_ff @(posedge aclk) begin
        logic [MW-1:0] m [4];
        logic [MW-1:0] b01, b23;
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                m[i] = v_reg[i][MW-1] ? MW'(-v_reg[i]) : MW'(v_reg[i]);
                mg_reg[i]     <= m[i];
                sgn_mg_reg[i] <= v_reg[i][MW-1];
            end
            b01 = (m[0] > m[1]) ? m[0] : m[1];
            b23 = (m[2] > m[3]) ? m[2] : m[3];
            mgb_reg <= (b01 > b23) ? b01 : b23;
            tmg_reg <= tvs_reg;
        end
    end

    // binary search shift: bring the largest magnitude into [2^29, 2^30)
    for (genvar k = 0; k < 5; k++) begin : g_norm
        localparam int S = 1 << (4 - k);
        logic [MW-1:0] mp [4];
        logic [MW-1:0] bp;
        logic [3:0]    sp;
        tail_t         tp;
        logic          vp;
        logic          rsh, lsh;

        if (k == 0) begin : g_first
            assign mp = mg_reg;
            assign bp = mgb_reg;
            assign sp = sgn_mg_reg;
            assign tp = tmg_reg;
            assign vp = mg_v_reg;
        end else begin : g_rest
            assign mp = nm_reg[k-1];
            assign bp = nb_reg[k-1];
            assign sp = nsg_reg[k-1];
            assign tp = ntl_reg[k-1];
            assign vp = nv_reg[k-1];
        end

        assign rsh = |bp[MW-1:29+S];
        assign lsh = ~|bp[MW-1:30-S];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                nv_reg[k] <= 1'b0;
            end else if (en) begin
                nv_reg[k] <= vp;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int i = 0; i < 4; i++) begin
                    nm_reg[k][i] <= rsh ? (mp[i] >> S) : (lsh ? (mp[i] << S) : mp[i]);
                end
                nb_reg[k]  <= rsh ? (bp >> S) : (lsh ? (bp << S) : bp);
                nsg_reg[k] <= sp;
                ntl_reg[k] <= tp;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                q2_reg[i]      <= nm_reg[4][i][29:0] * nm_reg[4][i][29:0];
                q2s_reg.mag[i] <= nm_reg[4][i][29:0];
            end
            q2s_reg.tl   <= ntl_reg[4];
            q2s_reg.sgn  <= nsg_reg[4];
            q2s_reg.zero <= (nb_reg[4] == '0);
            ss_reg  <= 62'(q2_reg[0]) + 62'(q2_reg[1]) + 62'(q2_reg[2]) + 62'(q2_reg[3]);
            sss_reg <= q2s_reg;
        end
    end

    qs_isqrt #(
        .NW (62),
        .SW ($bits(len_side_t))
    ) u_root_len (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (ss_v_reg),
        .num_in    (ss_reg),
        .side_in   (sss_reg),
        .out_valid (rt2_v),
        .root_out  (rt2_root),
        .side_out  (rt2_side)
    );

    assign rt2_s = len_side_t'(rt2_side);

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                nn_reg[i] <= {1'b0, rt2_s.mag[i], 16'b0} + 47'(rt2_root >> 1);
            end
            len_reg      <= rt2_root;
            nns_reg.tl   <= rt2_s.tl;
            nns_reg.sgn  <= rt2_s.sgn;
            nns_reg.zero <= rt2_s.zero;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < 17; k++) begin : g_div
        localparam int QB = 16 - k;
        logic [30:0] rp [4];
        logic [16:0] qp [4];
        logic [16:0] np [4];
        logic [30:0] lp;
        div_side_t   sp;
        logic        vp;

        if (k == 0) begin : g_first
            always_comb begin
                for (int i = 0; i < 4; i++) begin
                    rp[i] = 31'(nn_reg[i][46:17]);
                    qp[i] = '0;
                    np[i] = nn_reg[i][16:0];
                end
            end
            assign lp = len_reg;
            assign sp = nns_reg;
            assign vp = nn_v_reg;
        end else begin : g_rest
            assign rp = dr_reg[k-1];
            assign qp = dq_reg[k-1];
            assign np = dn_reg[k-1];
            assign lp = dl_reg[k-1];
            assign sp = ds_reg[k-1];
            assign vp = dv_reg[k-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[k] <= 1'b0;
            end else if (en) begin
                dv_reg[k] <= vp;
            end
        end

        always_ff @(posedge aclk) begin
            logic [31:0] r2;
            logic [16:0] qn;
            if (en) begin
                for (int i = 0; i < 4; i++) begin
                    r2 = {rp[i], np[i][QB]};
                    qn = qp[i];
                    if (r2 >= {1'b0, lp}) begin
                        qn[QB]       = 1'b1;
                        dr_reg[k][i] <= 31'(r2 - {1'b0, lp});
                    end else begin
                        dr_reg[k][i] <= r2[30:0];
                    end
                    dq_reg[k][i] <= qn;
                    dn_reg[k][i] <= np[i];
                end
                dl_reg[k] <= lp;
                ds_reg[k] <= sp;
            end
        end
    end

    // sign restore, saturation, the zero case and the direct cases
    always_comb begin
        fldw_t qs;
        fld_t  f;
        for (int i = 0; i < 4; i++) begin
            qs = $signed({2'b0, dq_reg[16][i]});
            f  = ds_reg[16].zero ? fld_t'(0) : sat_field(ds_reg[16].sgn[i] ? -qs : qs);
            o_next[i*FW +: FW] = ds_reg[16].tl.direct ? ds_reg[16].tl.r_dir[i] : f;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            o_reg <= o_next;
        end
    end

    assign m_tvalid = o_v_reg;
    assign m_tdata  = o_reg;

`ifndef SYNTHESIS
    a_no_valid_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_norm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        nv_reg[4] && (nb_reg[4] != '0) |-> (nb_reg[4][MW-1:30] == '0) && nb_reg[4][29])
        else $error("normalize shift left largest magnitude out of range");

    a_quot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        dv_reg[16] && !ds_reg[16].zero |->
            (dq_reg[16][0] <= ONE_Q16) && (dq_reg[16][1] <= ONE_Q16) &&
            (dq_reg[16][2] <= ONE_Q16) && (dq_reg[16][3] <= ONE_Q16))
        else $error("normalized component above one");
`endif

endmodule
